### rtl/core/mmp_pkg.sv
// ----------------------------------------------------------------------------
// mmp_pkg
// Shared constants and types for the MIDI channel message parser.
// ----------------------------------------------------------------------------
package mmp_pkg;

  // Status byte fields
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned NIBBLE_W = 4;
  localparam int unsigned DATA_W   = 7;
  localparam int unsigned BEND_W   = 14;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned EN_W     = 5;

  localparam logic [BEND_W-1:0] BEND_CENTER = 14'h2000;

  // Command nibbles (high nibble of a status byte)
  localparam logic [NIBBLE_W-1:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [NIBBLE_W-1:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [NIBBLE_W-1:0] CMD_CONTROL  = 4'hB;
  localparam logic [NIBBLE_W-1:0] CMD_PROGRAM  = 4'hC;
  localparam logic [NIBBLE_W-1:0] CMD_CH_TOUCH = 4'hD;
  localparam logic [NIBBLE_W-1:0] CMD_BEND     = 4'hE;

  // Reported message kind
  typedef enum logic [KIND_W-1:0] {
    KIND_NOTE_OFF = 3'd0,
    KIND_NOTE_ON  = 3'd1,
    KIND_CONTROL  = 3'd2,
    KIND_PROGRAM  = 3'd3,
    KIND_BEND     = 3'd4,
    KIND_OTHER    = 3'd5
  } kind_t;

  // Parse phase
  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_t;

endpackage : mmp_pkg

### rtl/core/mmp_if.sv
// ----------------------------------------------------------------------------
// mmp_if
// Valid/ready channels of the MIDI message parser: byte in, message out,
// configuration write.
// ----------------------------------------------------------------------------
interface mmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;

  modport source (output valid, output midi_byte, input ready);
  modport sink   (input valid, input midi_byte, output ready);
endinterface : mmp_byte_if

interface mmp_msg_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  message_kind;
  logic        [3:0]  channel_number;
  logic        [3:0]  command_nibble;
  logic        [6:0]  first_data;
  logic        [6:0]  second_data;
  logic signed [13:0] bend_value;

  modport source (output valid, output message_kind, output channel_number,
                  output command_nibble, output first_data, output second_data,
                  output bend_value, input ready);
  modport sink   (input valid, input message_kind, input channel_number,
                  input command_nibble, input first_data, input second_data,
                  input bend_value, output ready);
endinterface : mmp_msg_if

interface mmp_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] report_enable;

  modport source (output valid, output report_enable, input ready);
  modport sink   (input valid, input report_enable, output ready);
endinterface : mmp_cfg_if

### rtl/core/midi_message_parser.sv
// ----------------------------------------------------------------------------
// midi_message_parser
// Parses a stream of received MIDI bytes into channel messages.
// ----------------------------------------------------------------------------
// Takes one MIDI byte per beat on in_ch and returns at most one parsed message
// per byte on out_ch. A byte with bit 7 set always restarts parsing; program
// change and channel aftertouch finish after one data byte, all other commands
// after two, and there is no running status. Note off, note on, control
// change, program change and pitch bend are reported only when their bit in
// report_enable is set; every other command comes out as kind other. The block
// sustains one byte per cycle unless a finished message must wait for a stalled
// out_ch: each byte passes an input register, one level of decode logic and
// the result register, from which a message is offered on out_ch. The input
// register lets one more byte in while a result waits on out_ch. Write
// report_enable only while the parser is idle.
// ----------------------------------------------------------------------------
module midi_message_parser (
  input  logic        clk,
  input  logic        rst_n,
  mmp_byte_if.sink    in_ch,
  mmp_msg_if.source   out_ch,
  mmp_cfg_if.sink     cfg_ch
);
  import mmp_pkg::*;

  // Configuration
  logic [EN_W-1:0]     report_enable_r;

  // Input register
  logic                s1_valid_r;
  logic [BYTE_W-1:0]   s1_byte_r;

  // Parse state
  phase_t              phase_r, phase_nxt;
  logic [NIBBLE_W-1:0] held_channel_r, held_channel_nxt;
  logic [NIBBLE_W-1:0] held_command_r, held_command_nxt;
  logic [DATA_W-1:0]   held_first_r, held_first_nxt;

  // Result register
  logic                out_valid_r;
  kind_t               kind_r;
  logic [NIBBLE_W-1:0] channel_r;
  logic [NIBBLE_W-1:0] command_r;
  logic [DATA_W-1:0]   first_r;
  logic [DATA_W-1:0]   second_r;
  logic [BEND_W-1:0]   bend_r;

  // Decode results
  logic                complete;
  logic                emit;
  kind_t               kind_c;
  logic                kind_en;
  logic [DATA_W-1:0]   first_c;
  logic [DATA_W-1:0]   second_c;
  logic [BEND_W-1:0]   bend_c;

  logic                in_fire;
  logic                out_free;
  logic                s1_adv;
  logic                is_status;
  logic [DATA_W-1:0]   data_c;

  assign is_status = s1_byte_r[BYTE_W-1];
  assign data_c    = s1_byte_r[DATA_W-1:0];

  // Handshakes
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_adv       = s1_valid_r && (!emit || out_free);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_enable_r <= '0;
    end else if (cfg_ch.valid) begin
      report_enable_r <= cfg_ch.report_enable;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_ch.midi_byte;
    end
  end

  // Next parse state
  always_comb begin
    phase_nxt        = phase_r;
    held_channel_nxt = held_channel_r;
    held_command_nxt = held_command_r;
    held_first_nxt   = held_first_r;
    if (is_status) begin
      held_channel_nxt = s1_byte_r[NIBBLE_W-1:0];
      held_command_nxt = s1_byte_r[BYTE_W-1:NIBBLE_W];
      phase_nxt        = PH_FIRST;
    end else begin
      unique case (phase_r)
        PH_FIRST: begin
          held_first_nxt = data_c;
          if (held_command_r == CMD_PROGRAM || held_command_r == CMD_CH_TOUCH) begin
            phase_nxt = PH_STATUS;
          end else begin
            phase_nxt = PH_SECOND;
          end
        end
        PH_SECOND: phase_nxt = PH_STATUS;
        default:   phase_nxt = PH_STATUS;
      endcase
    end
  end

  // Message kind and its enable bit
  always_comb begin
    unique case (held_command_r)
      CMD_NOTE_OFF: begin kind_c = KIND_NOTE_OFF; kind_en = report_enable_r[0]; end
      CMD_NOTE_ON:  begin kind_c = KIND_NOTE_ON;  kind_en = report_enable_r[1]; end
      CMD_CONTROL:  begin kind_c = KIND_CONTROL;  kind_en = report_enable_r[2]; end
      CMD_PROGRAM:  begin kind_c = KIND_PROGRAM;  kind_en = report_enable_r[3]; end
      CMD_BEND:     begin kind_c = KIND_BEND;     kind_en = report_enable_r[4]; end
      default:      begin kind_c = KIND_OTHER;    kind_en = 1'b1; end
    endcase
  end

  // Completion and result fields
  always_comb begin
    complete = 1'b0;
    first_c  = held_first_r;
    second_c = '0;
    if (!is_status) begin
      unique case (phase_r)
        PH_FIRST: begin
          first_c  = data_c;
          complete = (held_command_r == CMD_PROGRAM) ||
                     (held_command_r == CMD_CH_TOUCH);
        end
        PH_SECOND: begin
          second_c = data_c;
          complete = 1'b1;
        end
        default: complete = 1'b0;
      endcase
    end
    emit   = complete && kind_en;
    // 14-bit bend word, second byte on top, recentered around zero
    bend_c = (kind_c == KIND_BEND) ? ({second_c, first_c} - BEND_CENTER) : '0;
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_STATUS;
      held_channel_r <= '0;
      held_command_r <= '0;
      held_first_r   <= '0;
    end else if (s1_adv) begin
      phase_r        <= phase_nxt;
      held_channel_r <= held_channel_nxt;
      held_command_r <= held_command_nxt;
      held_first_r   <= held_first_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      kind_r    <= kind_c;
      channel_r <= held_channel_r;
      command_r <= held_command_r;
      first_r   <= first_c;
      second_r  <= second_c;
      bend_r    <= bend_c;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.message_kind   = kind_r;
  assign out_ch.channel_number = channel_r;
  assign out_ch.command_nibble = command_r;
  assign out_ch.first_data     = first_r;
  assign out_ch.second_data    = second_r;
  assign out_ch.bend_value     = $signed(bend_r);

endmodule : midi_message_parser

### rtl/core/mmp_checker.sv
// ----------------------------------------------------------------------------
// mmp_checker
// Port-level checks for the MIDI message parser, bound to the top level.
// ----------------------------------------------------------------------------
module mmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [3:0]  out_command,
  input logic [6:0]  out_first,
  input logic [6:0]  out_second,
  input logic [13:0] out_bend
);
  import mmp_pkg::*;

  // No result right out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({out_kind, out_command, out_first,
                                          out_second, out_bend}))
    else $error("result payload changed while stalled");

  // Command nibble always comes from a status byte
  a_cmd_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_command[3])
    else $error("command nibble without status bit");

  // Bend value only on pitch bend results
  a_bend_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_BEND |-> out_bend == '0)
    else $error("bend value on a non-bend result");

endmodule : mmp_checker

bind midi_message_parser mmp_checker u_mmp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_kind    (out_ch.message_kind),
  .out_command (out_ch.command_nibble),
  .out_first   (out_ch.first_data),
  .out_second  (out_ch.second_data),
  .out_bend    (out_ch.bend_value)
);

### tb/tb_midi_message_parser.sv
// ----------------------------------------------------------------------------
// tb_midi_message_parser
// Self-checking testbench for the MIDI channel message parser.
// ----------------------------------------------------------------------------
// Drives MIDI bytes into in_ch and checks every message on out_ch against an
// expectation from a local parser model or from the directed table. A short
// directed table covers the edge values, every command and the corner cases.
// It is followed by random phases of well-formed messages, cut-short messages
// and stray data bytes, each under its own report_enable setting. The sender
// idles in random bursts. The receiver stalls on its own pattern, and once
// holds off long enough for the block to back up.
// ----------------------------------------------------------------------------
module tb_midi_message_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import mmp_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 200;
  localparam int NUM_PHASES    = 6;
  localparam int CYCLE_LIMIT   = 300000;

  // How a directed row is checked, or a register write
  typedef enum logic [1:0] {
    ST_MODEL, // expectation from the local parser
    ST_QUIET, // no message may follow this byte
    ST_MSG,   // expectation typed into the table
    ST_CFG    // write report_enable with the low bits of the byte
  } step_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  chan;
    logic [3:0]  cmd;
    logic [6:0]  first;
    logic [6:0]  second;
    logic [13:0] bend;
  } midi_msg_t;

  typedef struct packed {
    step_t      step;
    logic [7:0] b;
    midi_msg_t  msg;
  } step_row_t;

  typedef struct packed {
    step_t     step;
    midi_msg_t msg;
  } byte_tag_t;

  logic clk = 1'b0;
  logic rst_n;

  mmp_byte_if in_if ();
  mmp_msg_if  out_if ();
  mmp_cfg_if  cfg_if ();

  midi_message_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #CLK_HALF clk = ~clk;

  // Parser model state
  phase_t     parse_ph   = PH_STATUS;
  logic [3:0] held_chan  = '0;
  logic [3:0] held_cmd   = '0;
  logic [6:0] held_first = '0;
  logic [4:0] report_en  = '0;

  midi_msg_t pending_msgs [$];
  byte_tag_t offered_bytes [$];
  int        mismatches = 0;
  int        cycles     = 0;
  int        burst_left = 0;
  int        hold_req   = 0;

  // Directed stimulus; typed messages can be read straight off the status byte
  step_row_t dir_rows [29] = '{
    // report_enable still at reset: only the other kind comes out
    '{ST_QUIET, 8'h00, '0},  // data with no status held
    '{ST_QUIET, 8'hA5, '0},
    '{ST_QUIET, 8'h7F, '0},
    '{ST_MSG,   8'h00, '{KIND_OTHER, 4'h5, 4'hA, 7'h7F, 7'h00, 14'h0000}},
    '{ST_CFG,   8'h1F, '0},
    // note off, lowest data, top channel
    '{ST_QUIET, 8'h8F, '0},
    '{ST_QUIET, 8'h00, '0},
    '{ST_MSG,   8'h00, '{KIND_NOTE_OFF, 4'hF, CMD_NOTE_OFF, 7'h00, 7'h00, 14'h0000}},
    // note on with zero velocity stays a note on
    '{ST_QUIET, 8'h93, '0},
    '{ST_QUIET, 8'h7F, '0},
    '{ST_MSG,   8'h00, '{KIND_NOTE_ON, 4'h3, CMD_NOTE_ON, 7'h7F, 7'h00, 14'h0000}},
    '{ST_QUIET, 8'hB4, '0},
    '{ST_QUIET, 8'h07, '0},
    '{ST_MODEL, 8'h64, '0},
    '{ST_QUIET, 8'hC2, '0},
    '{ST_MSG,   8'h55, '{KIND_PROGRAM, 4'h2, CMD_PROGRAM, 7'h55, 7'h00, 14'h0000}},
    // bend at full scale up: +8191
    '{ST_QUIET, 8'hE0, '0},
    '{ST_QUIET, 8'h7F, '0},
    '{ST_MSG,   8'h7F, '{KIND_BEND, 4'h0, CMD_BEND, 7'h7F, 7'h7F, 14'h1FFF}},
    // bend at full scale down: -8192
    '{ST_QUIET, 8'hEE, '0},
    '{ST_QUIET, 8'h00, '0},
    '{ST_MSG,   8'h00, '{KIND_BEND, 4'hE, CMD_BEND, 7'h00, 7'h00, 14'h2000}},
    // channel aftertouch: one data byte, kind other
    '{ST_QUIET, 8'hDA, '0},
    '{ST_MSG,   8'h11, '{KIND_OTHER, 4'hA, CMD_CH_TOUCH, 7'h11, 7'h00, 14'h0000}},
    // real-time byte cuts a control change short, then parses as system
    '{ST_QUIET, 8'hB1, '0},
    '{ST_QUIET, 8'h07, '0},
    '{ST_QUIET, 8'hF8, '0},
    '{ST_QUIET, 8'h22, '0},
    '{ST_MSG,   8'h33, '{KIND_OTHER, 4'h8, 4'hF, 7'h22, 7'h33, 14'h0000}}
  };

  // Build the message for the held status; 0 when its kind is masked off
  function automatic bit form_message(input logic [6:0] second, output midi_msg_t m);
    kind_t k;
    m = '0;
    case (held_cmd)
      CMD_NOTE_OFF: k = KIND_NOTE_OFF;
      CMD_NOTE_ON:  k = KIND_NOTE_ON;
      CMD_CONTROL:  k = KIND_CONTROL;
      CMD_PROGRAM:  k = KIND_PROGRAM;
      CMD_BEND:     k = KIND_BEND;
      default:      k = KIND_OTHER;
    endcase
    if (k != KIND_OTHER && !report_en[k]) return 1'b0;
    m.kind   = k;
    m.chan   = held_chan;
    m.cmd    = held_cmd;
    m.first  = held_first;
    m.second = second;
    m.bend   = (k == KIND_BEND) ? ({second, held_first} - BEND_CENTER) : '0;
    return 1'b1;
  endfunction

  // Advance the parser model by one byte; 1 when a message comes out
  function automatic bit parse_midi_byte(input logic [7:0] b, output midi_msg_t m);
    m = '0;
    if (b[7]) begin
      held_chan = b[3:0];
      held_cmd  = b[7:4];
      parse_ph  = PH_FIRST;
      return 1'b0;
    end
    case (parse_ph)
      PH_FIRST: begin
        held_first = b[6:0];
        if (held_cmd == CMD_PROGRAM || held_cmd == CMD_CH_TOUCH) begin
          parse_ph = PH_STATUS;
          return form_message(7'h00, m);
        end
        parse_ph = PH_SECOND;
        return 1'b0;
      end
      PH_SECOND: begin
        parse_ph = PH_STATUS;
        return form_message(b[6:0], m);
      end
      default: begin
        parse_ph = PH_STATUS;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic signed [31:0] exp_v,
                                        input logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Offer one byte, idling between bursts, and hold until it is taken
  task automatic offer_byte(input logic [7:0] b, input step_t step, input midi_msg_t msg);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    offered_bytes.push_back('{step, msg});
    in_if.valid     <= 1'b1;
    in_if.midi_byte <= b;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Stop sending and let every message and any partial work leave the block
  task automatic drain_parser();
    in_if.valid <= 1'b0;
    while (offered_bytes.size() != 0 || pending_msgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_report_enable(input logic [4:0] v);
    cfg_if.valid         <= 1'b1;
    cfg_if.report_enable <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    report_en = v;
  endtask

  // Mostly complete messages with random content, some cut short, some stray data
  task automatic random_phase(input int n_items);
    int         sent;
    int         r;
    int         n_data;
    logic [7:0] st;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        offer_byte(8'($urandom_range(0, 127)), ST_MODEL, '0);
        sent++;
      end else begin
        st     = 8'($urandom_range(8'h80, 8'hFF));
        n_data = (st[7:4] == CMD_PROGRAM || st[7:4] == CMD_CH_TOUCH) ? 1 : 2;
        if (r >= 90) n_data = $urandom_range(0, n_data - 1);
        offer_byte(st, ST_MODEL, '0);
        sent++;
        repeat (n_data) begin
          offer_byte(8'($urandom_range(0, 127)), ST_MODEL, '0);
          sent++;
        end
      end
    end
  endtask

  // Predict on every accepted byte
  always @(posedge clk) begin
    byte_tag_t tag;
    midi_msg_t m;
    bit        hit;
    if (rst_n && in_if.valid && in_if.ready) begin
      tag = offered_bytes.pop_front();
      hit = parse_midi_byte(in_if.midi_byte, m);
      case (tag.step)
        ST_MODEL: if (hit) pending_msgs.push_back(m);
        ST_MSG:   pending_msgs.push_back(tag.msg);
        default:  ;
      endcase
    end
  end

  // Check every accepted message against the oldest expectation
  always @(posedge clk) begin
    midi_msg_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_msgs.size() == 0) begin
        $error("message with none expected: kind %0d channel %0d command %0h",
               out_if.message_kind, out_if.channel_number, out_if.command_nibble);
        mismatches++;
      end else begin
        want = pending_msgs.pop_front();
        compare_field("message_kind",   32'(want.kind),   32'(out_if.message_kind));
        compare_field("channel_number", 32'(want.chan),   32'(out_if.channel_number));
        compare_field("command_nibble", 32'(want.cmd),    32'(out_if.command_nibble));
        compare_field("first_data",     32'(want.first),  32'(out_if.first_data));
        compare_field("second_data",    32'(want.second), 32'(out_if.second_data));
        compare_field("bend_value",     32'($signed(want.bend)), 32'(out_if.bend_value));
      end
    end
  end

  // Receiver: runs of steady, random or sparse ready, plus one long hold-off
  int hold_ack  = 0;
  int hold_left = 0;
  int rx_mode   = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (hold_req != hold_ack) begin
      hold_ack     = hold_req;
      hold_left    = LONG_HOLD;
      out_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      case (rx_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(0, 1));
        default: out_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int         idx;
    logic [4:0] en;
    logic [4:0] fixed_en [4];
    fixed_en = '{5'h1F, 5'h00, 5'h15, 5'h0A};

    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.midi_byte      = '0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.report_enable = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (idx = 0; idx < $size(dir_rows); idx++) begin
      if (dir_rows[idx].step == ST_CFG) begin
        drain_parser();
        write_report_enable(dir_rows[idx].b[4:0]);
      end else begin
        offer_byte(dir_rows[idx].b, dir_rows[idx].step, dir_rows[idx].msg);
      end
    end
    drain_parser();

    // Random phases, each under its own enable mask
    for (idx = 0; idx < NUM_PHASES; idx++) begin
      en = (idx < 4) ? fixed_en[idx] : 5'($urandom_range(0, 31));
      write_report_enable(en);
      if (idx == 0) hold_req++;
      random_phase(PHASE_ITEMS);
      drain_parser();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule : tb_midi_message_parser
